/* sv/imaenc_pkg.sv */
// Shared types, constants and tables of the IMA ADPCM encoder.
`default_nettype none

package imaenc_pkg;

  localparam int StepLast   = 88;
  localparam int StepCount  = 89;
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic signed [15:0] PcmMax = 16'sh7fff;
  localparam logic signed [15:0] PcmMin = 16'sh8000;

  // Input transaction
  typedef struct packed {
    logic signed [15:0] sample;
    logic               buffer_end;
    logic               clear_state;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] packed_byte;
    logic       ends_buffer;
  } result_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [15:0] sample;
    logic               clear_state;
    logic               buffer_end;
    logic               emit;    // this sample completes a byte
    logic               second;  // this sample is the upper nibble
  } work_t;

  // Quantizer step sizes
  localparam logic [14:0] StepRom [StepCount] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,
    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,
    15'd28,    15'd31,    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,
    15'd55,    15'd60,    15'd66,    15'd73,    15'd80,    15'd88,    15'd97,
    15'd107,   15'd118,   15'd130,   15'd143,   15'd157,   15'd173,   15'd190,
    15'd209,   15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
    15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,   15'd724,
    15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,
    15'd3024,  15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,
    15'd5894,  15'd6484,  15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442,
    15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
    15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
  };

  // Step index adjustment by code magnitude
  function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
    logic signed [4:0] adj;
    case (mag)
      3'd4:    adj = 5'sd2;
      3'd5:    adj = 5'sd4;
      3'd6:    adj = 5'sd6;
      3'd7:    adj = 5'sd8;
      default: adj = -5'sd1;
    endcase
    return adj;
  endfunction

endpackage

`default_nettype wire

/* sv/imaenc_fifo.sv */
// Short queue of classified items between front and back.
`default_nettype none

module imaenc_fifo
  import imaenc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  work_t      data_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output work_t      data_o,
  output logic       empty_o
);

  work_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointer and fill count
  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/imaenc_front.sv */
// Front end: accepts samples and tags each with its place in the nibble pair.
`default_nettype none

module imaenc_front
  import imaenc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  input  item_t      item_i,
  output logic       full,
  output logic       q_push_o,
  output work_t      q_data_o,
  input  wire logic  q_full_i
);

  logic waiting_q, waiting_d;

  assign full     = q_full_i;
  assign q_push_o = push;

  // Classify: a byte is emitted on the second nibble or on a buffer end
  always_comb begin
    q_data_o.sample      = item_i.sample;
    q_data_o.clear_state = item_i.clear_state;
    q_data_o.buffer_end  = item_i.buffer_end;
    q_data_o.second      = waiting_q;
    q_data_o.emit        = waiting_q || item_i.buffer_end;
    waiting_d            = waiting_q;
    if (push && !q_full_i) begin
      waiting_d = !waiting_q && !item_i.buffer_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= 1'b0;
    end else begin
      waiting_q <= waiting_d;
    end
  end

endmodule

`default_nettype wire

/* sv/imaenc_back.sv */
// Back end: ADPCM quantizer, predictor update, nibble packing and result buffer.
`default_nettype none

module imaenc_back
  import imaenc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  work_t      q_data_i,
  input  wire logic  q_empty_i,
  output logic       q_pop_o,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result_o
);

  // Encoder state
  logic signed [15:0] pred_q, pred_d;
  logic [6:0]         pos_q, pos_d;
  logic [3:0]         held_q, held_d;

  // Two-entry result buffer
  result_t     out_mem_q [2];
  logic        out_wr_q, out_rd_q;
  logic [1:0]  out_cnt_q, out_cnt_d;
  logic        out_pop, out_wr, room, take;

  // Datapath
  logic [6:0]         pos_raw, pos;
  logic signed [15:0] pred;
  logic [14:0]        step;
  logic signed [16:0] diff;
  logic [16:0]        mag0, mag1, mag2, step_x;
  logic               neg, c2, c1, c0;
  logic [16:0]        delta;
  logic signed [17:0] sum;
  logic signed [4:0]  adj;
  logic signed [8:0]  idx;
  logic [3:0]         code;
  result_t            res;

  assign out_pop  = pop && (out_cnt_q != 2'd0);
  assign room     = (out_cnt_q != 2'd2) || out_pop;
  assign take     = !q_empty_i && room;
  assign q_pop_o  = take;
  assign out_wr   = take && q_data_i.emit;
  assign empty    = (out_cnt_q == 2'd0);
  assign result_o = out_mem_q[out_rd_q];

  // Quantize the difference against the current step
  always_comb begin
    pos_raw = q_data_i.clear_state ? 7'd0 : pos_q;
    pos     = (pos_raw > 7'(StepLast)) ? 7'(StepLast) : pos_raw;
    pred    = q_data_i.clear_state ? 16'sd0 : pred_q;
    step    = StepRom[pos];
    step_x  = {2'b00, step};
    diff    = {q_data_i.sample[15], q_data_i.sample} - {pred[15], pred};
    neg     = diff[16];
    mag0    = neg ? 17'(-diff) : 17'(diff);
    c2      = (mag0 >= step_x);
    mag1    = c2 ? mag0 - step_x : mag0;
    c1      = (mag1 >= (step_x >> 1));
    mag2    = c1 ? mag1 - (step_x >> 1) : mag1;
    c0      = (mag2 >= (step_x >> 2));
    code    = {neg, c2, c1, c0};
  end

  // Predictor and step index update
  always_comb begin
    delta = (step_x >> 3)
          + (c2 ? step_x : 17'd0)
          + (c1 ? (step_x >> 1) : 17'd0)
          + (c0 ? (step_x >> 2) : 17'd0);
    if (neg) begin
      sum = {{2{pred[15]}}, pred} - {1'b0, delta};
    end else begin
      sum = {{2{pred[15]}}, pred} + {1'b0, delta};
    end
    adj = index_adjust(code[2:0]);
    idx = {2'b00, pos} + {{4{adj[4]}}, adj};

    pred_d = pred_q;
    pos_d  = pos_q;
    held_d = held_q;
    if (take) begin
      if (sum > 18'sd32767) begin
        pred_d = PcmMax;
      end else if (sum < -18'sd32768) begin
        pred_d = PcmMin;
      end else begin
        pred_d = sum[15:0];
      end
      if (idx < 9'sd0) begin
        pos_d = 7'd0;
      end else if (idx > 9'(StepLast)) begin
        pos_d = 7'(StepLast);
      end else begin
        pos_d = idx[6:0];
      end
      held_d = q_data_i.emit ? 4'd0 : code;
    end
  end

  // Byte assembly
  always_comb begin
    res.packed_byte = q_data_i.second ? {code, held_q} : {4'd0, code};
    res.ends_buffer = q_data_i.buffer_end;
    out_cnt_d       = out_cnt_q;
    if (out_wr && !out_pop) begin
      out_cnt_d = out_cnt_q + 2'd1;
    end else if (!out_wr && out_pop) begin
      out_cnt_d = out_cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pred_q    <= '0;
      pos_q     <= '0;
      held_q    <= '0;
      out_wr_q  <= 1'b0;
      out_rd_q  <= 1'b0;
      out_cnt_q <= '0;
    end else begin
      pred_q    <= pred_d;
      pos_q     <= pos_d;
      held_q    <= held_d;
      out_cnt_q <= out_cnt_d;
      if (out_wr) begin
        out_wr_q <= !out_wr_q;
      end
      if (out_pop) begin
        out_rd_q <= !out_rd_q;
      end
    end
  end

  // Result storage
  always_ff @(posedge clk_i) begin
    if (out_wr) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

endmodule

`default_nettype wire

/* sv/ima_adpcm_encoder.sv */
// Top level of the IMA ADPCM encoder with two-codes-per-byte packing.
// Path: an accepted sample is registered in the input queue, and the byte it completes
// is then registered in the result buffer, from which it shows on the result ports.
// Throughput: one sample per cycle, set by the predictor/step-index loop, while the
// result buffer has room; input and result queues let both sides stall independently.
// Reset (rst_ni low, async) empties all queues and zeroes predictor, step index
// and the held nibble.
`default_nettype none

module ima_adpcm_encoder
  import imaenc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push,
  output logic       full,
  input  item_t      item_i,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result_o
);

  logic  q_push, q_full, q_pop, q_empty;
  work_t q_wdata, q_rdata;

  imaenc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .item_i   (item_i),
    .full     (full),
    .q_push_o (q_push),
    .q_data_o (q_wdata),
    .q_full_i (q_full)
  );

  imaenc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  imaenc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_rdata),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .result_o  (result_o)
  );

endmodule

`default_nettype wire

/* sv/imaenc_checker.sv */
// Port-level checks of the encoder, bound to the top level.
`default_nettype none

module imaenc_checker
  import imaenc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input result_t   result_o
);

  logic seen_q;

  // Remembers whether any transaction has been accepted since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push && !full) begin
      seen_q <= 1'b1;
    end
  end

  // Nothing to deliver while in reset
  a_empty_in_reset: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // No result without an accepted sample
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> seen_q)
    else $error("result before any sample was accepted");

  // A waiting result stays
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

  // A waiting result keeps its value
  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o))
    else $error("waiting result changed");

endmodule

bind ima_adpcm_encoder imaenc_checker u_checker (.*);

`default_nettype wire
